/* rtl/dotq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared codes and helpers for the deadline-ordered task timer queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

    localparam int TICK_W = 32;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_CREATE   = 3'd1,
        MODE_DELETE   = 3'd2,
        MODE_POLL     = 3'd3,
        MODE_COMPLETE = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_PARAM       = 3'd1,
        ST_FULL        = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_NOTHING_DUE = 3'd4,
        ST_SEQUENCE    = 3'd5
    } status_t;

    // Per-cell shift command
    typedef enum logic [1:0] {
        CMD_HOLD      = 2'd0,
        CMD_TAKE_PREV = 2'd1,
        CMD_TAKE_NEXT = 2'd2,
        CMD_TAKE_NEW  = 2'd3
    } cell_cmd_t;

    // Wrap-aware ordering: a is before b
    function automatic logic is_before(input logic [TICK_W-1:0] a,
                                       input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] diff;
        diff = a - b;
        return diff[TICK_W-1];
    endfunction

endpackage
`default_nettype wire

/* rtl/dotq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_cell
// One position of the sorted queue; shifts toward either neighbor.
// ----------------------------------------------------------------------------
module dotq_cell #(
    parameter int ID_BITS = 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire dotq_pkg::cell_cmd_t     cmd,
    input  wire                          prev_valid,
    input  wire [ID_BITS-1:0]            prev_id,
    input  wire [dotq_pkg::WORD_W-1:0]   prev_arg,
    input  wire [dotq_pkg::WORD_W-1:0]   prev_period,
    input  wire [dotq_pkg::TICK_W-1:0]   prev_dl,
    input  wire                          next_valid,
    input  wire [ID_BITS-1:0]            next_id,
    input  wire [dotq_pkg::WORD_W-1:0]   next_arg,
    input  wire [dotq_pkg::WORD_W-1:0]   next_period,
    input  wire [dotq_pkg::TICK_W-1:0]   next_dl,
    input  wire [ID_BITS-1:0]            new_id,
    input  wire [dotq_pkg::WORD_W-1:0]   new_arg,
    input  wire [dotq_pkg::WORD_W-1:0]   new_period,
    input  wire [dotq_pkg::TICK_W-1:0]   new_dl,
    output logic                         valid,
    output logic [ID_BITS-1:0]           id,
    output logic [dotq_pkg::WORD_W-1:0]  arg,
    output logic [dotq_pkg::WORD_W-1:0]  period,
    output logic [dotq_pkg::TICK_W-1:0]  dl,
    output logic                         match,
    output logic                         after
);

    logic                         valid_reg, valid_next;
    logic [ID_BITS-1:0]           id_reg;
    logic [dotq_pkg::WORD_W-1:0]  arg_reg, period_reg;
    logic [dotq_pkg::TICK_W-1:0]  dl_reg;

    always_comb
    begin
        case (cmd)
            dotq_pkg::CMD_TAKE_PREV: valid_next = prev_valid;
            dotq_pkg::CMD_TAKE_NEXT: valid_next = next_valid;
            dotq_pkg::CMD_TAKE_NEW:  valid_next = 1'b1;
            default:                 valid_next = valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            dotq_pkg::CMD_TAKE_PREV:
            begin
                id_reg <= prev_id; arg_reg <= prev_arg;
                period_reg <= prev_period; dl_reg <= prev_dl;
            end
            dotq_pkg::CMD_TAKE_NEXT:
            begin
                id_reg <= next_id; arg_reg <= next_arg;
                period_reg <= next_period; dl_reg <= next_dl;
            end
            dotq_pkg::CMD_TAKE_NEW:
            begin
                id_reg <= new_id; arg_reg <= new_arg;
                period_reg <= new_period; dl_reg <= new_dl;
            end
            default:
            begin
                id_reg <= id_reg;
            end
        endcase
    end

    assign valid  = valid_reg;
    assign id     = id_reg;
    assign arg    = arg_reg;
    assign period = period_reg;
    assign dl     = dl_reg;
    assign match  = valid_reg && (id_reg == new_id);
    // new entry sorts behind this one (ties stay behind)
    assign after  = valid_reg && !dotq_pkg::is_before(new_dl, dl_reg);

endmodule
`default_nettype wire

/* rtl/deadline_ordered_task_timer_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_ordered_task_timer_queue
// Tick counter plus a deadline-sorted queue of timed tasks in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid/in_ready) carries mode, task_id, task_arg,
//    delay, period, run_result. Response channel (out_valid/out_ready)
//    returns status, due_task_id, due_task_arg, current_tick; exactly one
//    response per request, in order.
//  - The queue is a chain of POOL_SLOTS cells kept sorted by wrap-aware
//    deadline, head at cell 0. Remove shifts the tail toward the head,
//    insert shifts it away; the top derives each cell's shift command.
//  - Flow: tick, delete, poll and a dropped complete answer from the work
//    state; create makes a remove pass in the work state, then an insert
//    pass in the insert state; a re-armed complete goes on to the insert pass.
//  - One request is in the block at a time; in_ready is high only when idle
//    and the response register is empty, so a new request is taken only
//    after the response to the last one has been accepted.
//  - A stalled receiver holds the response; no request is taken meanwhile.
//  - Reset clears the tick, all cell valid bits, the in-flight task and
//    the response valid bit. Cell payloads are not reset.
// ----------------------------------------------------------------------------
module deadline_ordered_task_timer_queue #(
    parameter int POOL_SLOTS = 16,
    parameter int ID_BITS    = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [2:0]   mode,
    input  wire [7:0]   task_id,
    input  wire [31:0]  task_arg,
    input  wire [31:0]  delay,
    input  wire [31:0]  period,
    input  wire         run_result,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [2:0]  status,
    output logic [7:0]  due_task_id,
    output logic [31:0] due_task_arg,
    output logic [31:0] current_tick
);

    localparam int QW = $clog2(POOL_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORK = 3'b010,
        S_INS  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [2:0]          mode_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [31:0]         arg_reg, delay_reg, period_reg;
    logic                keep_reg;

    // entry waiting for the insert pass
    logic [ID_BITS-1:0]  ins_id_reg, ins_id_next;
    logic [31:0]         ins_arg_reg, ins_arg_next;
    logic [31:0]         ins_period_reg, ins_period_next;
    logic [31:0]         ins_dl_reg, ins_dl_next;

    logic [31:0]         tick_reg, tick_next;
    logic [QW-1:0]       qlen_reg, qlen_next;

    logic                fl_valid_reg, fl_valid_next;
    logic [ID_BITS-1:0]  fl_id_reg, fl_id_next;
    logic [31:0]         fl_arg_reg, fl_arg_next;
    logic [31:0]         fl_period_reg, fl_period_next;
    logic [31:0]         fl_dl_reg, fl_dl_next;

    logic                ov_reg, ov_next;
    logic [2:0]          st_reg, st_next;
    logic [7:0]          did_reg, did_next;
    logic [31:0]         darg_reg, darg_next;
    logic [31:0]         ctick_reg, ctick_next;

    // chain
    logic                c_valid  [POOL_SLOTS];
    logic [ID_BITS-1:0]  c_id     [POOL_SLOTS];
    logic [31:0]         c_arg    [POOL_SLOTS];
    logic [31:0]         c_period [POOL_SLOTS];
    logic [31:0]         c_dl     [POOL_SLOTS];
    logic                c_match  [POOL_SLOTS];
    logic                c_after  [POOL_SLOTS];
    dotq_pkg::cell_cmd_t c_cmd    [POOL_SLOTS];

    logic [ID_BITS-1:0]  key_id;
    logic                rm_en, pop_en, ins_en, any_match, ins_seen;
    logic                rm_pre   [POOL_SLOTS];
    logic [31:0]         rearm_dl, rearm_sum;
    logic [QW:0]         occupied;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign key_id   = (state_reg == S_INS) ? ins_id_reg : id_reg;
    assign rearm_sum = fl_dl_reg + fl_period_reg;
    assign rearm_dl  = dotq_pkg::is_before(rearm_sum, tick_reg) ?
                       (tick_reg + fl_period_reg) : rearm_sum;
    assign occupied  = {1'b0, qlen_reg} + {{QW{1'b0}}, fl_valid_reg};

    // first matching cell and everything behind it shift forward; a pop shifts all
    always_comb
    begin
        any_match = 1'b0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            any_match = any_match | c_match[i];
            rm_pre[i] = pop_en | any_match;
        end
    end

    // new entry lands in the first cell it sorts ahead of; all behind shift back
    always_comb
    begin
        ins_seen = 1'b0;
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            c_cmd[i] = dotq_pkg::CMD_HOLD;
            if (rm_en && rm_pre[i])
                c_cmd[i] = dotq_pkg::CMD_TAKE_NEXT;
            else if (ins_en && (ins_seen || !c_after[i]))
            begin
                if (ins_seen)
                    c_cmd[i] = dotq_pkg::CMD_TAKE_PREV;
                else
                    c_cmd[i] = dotq_pkg::CMD_TAKE_NEW;
            end
            ins_seen = ins_seen | !c_after[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < POOL_SLOTS; g++)
        begin : g_cell
            localparam int PI = (g > 0) ? g - 1 : 0;
            localparam int NI = (g < POOL_SLOTS - 1) ? g + 1 : g;
            localparam bit LAST = (g == POOL_SLOTS - 1);
            dotq_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (c_cmd[g]),
                .prev_valid  (c_valid[PI]),
                .prev_id     (c_id[PI]),
                .prev_arg    (c_arg[PI]),
                .prev_period (c_period[PI]),
                .prev_dl     (c_dl[PI]),
                .next_valid  (LAST ? 1'b0 : c_valid[NI]),
                .next_id     (c_id[NI]),
                .next_arg    (c_arg[NI]),
                .next_period (c_period[NI]),
                .next_dl     (c_dl[NI]),
                .new_id      (key_id),
                .new_arg     (ins_arg_reg),
                .new_period  (ins_period_reg),
                .new_dl      (ins_dl_reg),
                .valid       (c_valid[g]),
                .id          (c_id[g]),
                .arg         (c_arg[g]),
                .period      (c_period[g]),
                .dl          (c_dl[g]),
                .match       (c_match[g]),
                .after       (c_after[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        qlen_next       = qlen_reg;
        fl_valid_next   = fl_valid_reg;
        fl_id_next      = fl_id_reg;
        fl_arg_next     = fl_arg_reg;
        fl_period_next  = fl_period_reg;
        fl_dl_next      = fl_dl_reg;
        ins_id_next     = ins_id_reg;
        ins_arg_next    = ins_arg_reg;
        ins_period_next = ins_period_reg;
        ins_dl_next     = ins_dl_reg;
        ov_next         = ov_reg && !out_ready;
        st_next         = st_reg;
        did_next        = did_reg;
        darg_next       = darg_reg;
        ctick_next      = ctick_reg;
        rm_en           = 1'b0;
        pop_en          = 1'b0;
        ins_en          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = S_WORK;
            end
            S_WORK:
            begin
                state_next = S_IDLE;
                ov_next    = 1'b1;
                st_next    = dotq_pkg::ST_OK;
                did_next   = '0;
                darg_next  = '0;
                case (mode_reg)
                    dotq_pkg::MODE_TICK:
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    dotq_pkg::MODE_CREATE:
                    begin
                        if (id_reg == '0)
                            st_next = dotq_pkg::ST_PARAM;
                        else
                        begin
                            rm_en = 1'b1;
                            if (any_match)
                                qlen_next = qlen_reg - QW'(1);
                            ins_id_next     = id_reg;
                            ins_arg_next    = arg_reg;
                            ins_period_next = period_reg;
                            ins_dl_next     = tick_reg + delay_reg;
                            ov_next         = ov_reg && !out_ready;
                            state_next      = S_INS;
                        end
                    end
                    dotq_pkg::MODE_DELETE:
                    begin
                        if (id_reg == '0)
                            st_next = dotq_pkg::ST_PARAM;
                        else if (any_match)
                        begin
                            rm_en     = 1'b1;
                            qlen_next = qlen_reg - QW'(1);
                        end
                        else
                            st_next = dotq_pkg::ST_NOT_FOUND;
                    end
                    dotq_pkg::MODE_POLL:
                    begin
                        if (fl_valid_reg)
                            st_next = dotq_pkg::ST_SEQUENCE;
                        else if (!c_valid[0] || dotq_pkg::is_before(tick_reg, c_dl[0]))
                            st_next = dotq_pkg::ST_NOTHING_DUE;
                        else
                        begin
                            rm_en          = 1'b1;
                            pop_en         = 1'b1;
                            qlen_next      = qlen_reg - QW'(1);
                            fl_valid_next  = 1'b1;
                            fl_id_next     = c_id[0];
                            fl_arg_next    = c_arg[0];
                            fl_period_next = c_period[0];
                            fl_dl_next     = c_dl[0];
                            did_next       = 8'(c_id[0]);
                            darg_next      = c_arg[0];
                        end
                    end
                    dotq_pkg::MODE_COMPLETE:
                    begin
                        if (!fl_valid_reg)
                            st_next = dotq_pkg::ST_SEQUENCE;
                        else
                        begin
                            fl_valid_next  = 1'b0;
                            fl_id_next     = '0;
                            fl_arg_next    = '0;
                            fl_period_next = '0;
                            fl_dl_next     = '0;
                            if (fl_period_reg != '0 && keep_reg)
                            begin
                                ins_id_next     = fl_id_reg;
                                ins_arg_next    = fl_arg_reg;
                                ins_period_next = fl_period_reg;
                                ins_dl_next     = rearm_dl;
                                ov_next         = ov_reg && !out_ready;
                                state_next      = S_INS;
                            end
                        end
                    end
                    default:
                    begin
                        st_next = dotq_pkg::ST_PARAM;
                    end
                endcase
                ctick_next = tick_next;
            end
            S_INS:
            begin
                state_next = S_IDLE;
                ov_next    = 1'b1;
                did_next   = '0;
                darg_next  = '0;
                ctick_next = tick_reg;
                // a re-armed task already owns its slot
                if (mode_reg == dotq_pkg::MODE_COMPLETE ||
                    occupied < (QW + 1)'(POOL_SLOTS))
                begin
                    ins_en    = 1'b1;
                    qlen_next = qlen_reg + QW'(1);
                    st_next   = dotq_pkg::ST_OK;
                end
                else
                    st_next = dotq_pkg::ST_FULL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            qlen_reg      <= '0;
            fl_valid_reg  <= 1'b0;
            fl_id_reg     <= '0;
            fl_arg_reg    <= '0;
            fl_period_reg <= '0;
            fl_dl_reg     <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            qlen_reg      <= qlen_next;
            fl_valid_reg  <= fl_valid_next;
            fl_id_reg     <= fl_id_next;
            fl_arg_reg    <= fl_arg_next;
            fl_period_reg <= fl_period_next;
            fl_dl_reg     <= fl_dl_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg   <= mode;
            id_reg     <= ID_BITS'(task_id);
            arg_reg    <= task_arg;
            delay_reg  <= delay;
            period_reg <= period;
            keep_reg   <= !run_result;
        end
        ins_id_reg     <= ins_id_next;
        ins_arg_reg    <= ins_arg_next;
        ins_period_reg <= ins_period_next;
        ins_dl_reg     <= ins_dl_next;
        st_reg         <= st_next;
        did_reg        <= did_next;
        darg_reg       <= darg_next;
        ctick_reg      <= ctick_next;
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign due_task_id  = did_reg;
    assign due_task_arg = darg_reg;
    assign current_tick = ctick_reg;

endmodule
`default_nettype wire

/* rtl/dotq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dotq_checker
// Port-level checks for the task timer queue.
// ----------------------------------------------------------------------------
module dotq_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [2:0]  status,
    input wire [7:0]  due_task_id,
    input wire [31:0] due_task_arg,
    input wire [31:0] current_tick
);

    // stalled response holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(current_tick) && $stable(due_task_arg))
        else $error("response changed while stalled");

    // one request in the block at a time
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // no request while a response waits
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("ready with pending response");

    // a failed request reports no task
    a_due: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dotq_pkg::ST_OK |->
        due_task_id == 8'd0 && due_task_arg == 32'd0)
        else $error("task reported without dispatch");

endmodule

bind deadline_ordered_task_timer_queue dotq_checker u_dotq_checker (.*);
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the deadline-ordered task timer queue against an in-bench predictor
// of its tick, sorted task list and in-flight register, under random stalls.
// ----------------------------------------------------------------------------

// Scoreboard: mirrors the timer queue and keeps the expected responses.
class timer_queue_scoreboard;
    localparam int SLOTS = 16;

    typedef struct packed {
        dotq_pkg::status_t status;
        logic [7:0]        due_id;
        logic [31:0]       due_arg;
        logic [31:0]       tick;
    } response_t;

    response_t   pending[$];
    int          errors;

    logic [31:0] now;
    logic        used [SLOTS];
    logic [7:0]  slot_id [SLOTS];
    logic [31:0] slot_arg [SLOTS];
    logic [31:0] slot_period [SLOTS];
    logic [31:0] slot_deadline [SLOTS];
    int          order[$];
    logic        busy;
    int          busy_slot;
    logic [31:0] busy_period;
    logic [31:0] busy_deadline;

    function new();
        errors = 0;
        now = '0;
        busy = 1'b0;
        busy_slot = 0;
        busy_period = '0;
        busy_deadline = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            used[i] = 1'b0;
        end
    endfunction

    function bit earlier(logic [31:0] a, logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    // Ahead of the first strictly later deadline, so ties stay in order.
    function void enqueue(int s);
        int pos;
        pos = 0;
        while (pos < order.size() && !earlier(slot_deadline[s], slot_deadline[order[pos]]))
        begin
            pos++;
        end
        order.insert(pos, s);
    endfunction

    function bit drop_queued(logic [7:0] id);
        foreach (order[p])
        begin
            if (slot_id[order[p]] == id)
            begin
                used[order[p]] = 1'b0;
                order.delete(p);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Mirror one accepted request and queue its response.
    function void note_request(logic [2:0] mode, logic [7:0] id, logic [31:0] arg,
                               logic [31:0] delay, logic [31:0] period, logic done);
        response_t r;
        int s;
        r.status = dotq_pkg::ST_OK;
        r.due_id = '0;
        r.due_arg = '0;
        case (mode)
            dotq_pkg::MODE_TICK:
                now = now + 1;
            dotq_pkg::MODE_CREATE:
                if (id == 0)
                    r.status = dotq_pkg::ST_PARAM;
                else
                begin
                    void'(drop_queued(id));
                    s = 0;
                    while (s < SLOTS && used[s])
                        s++;
                    if (s >= SLOTS)
                        r.status = dotq_pkg::ST_FULL;
                    else
                    begin
                        used[s] = 1'b1;
                        slot_id[s] = id;
                        slot_arg[s] = arg;
                        slot_period[s] = period;
                        slot_deadline[s] = now + delay;
                        enqueue(s);
                    end
                end
            dotq_pkg::MODE_DELETE:
                if (id == 0)
                    r.status = dotq_pkg::ST_PARAM;
                else if (!drop_queued(id))
                    r.status = dotq_pkg::ST_NOT_FOUND;
            dotq_pkg::MODE_POLL:
                if (busy)
                    r.status = dotq_pkg::ST_SEQUENCE;
                else if (order.size() == 0 || earlier(now, slot_deadline[order[0]]))
                    r.status = dotq_pkg::ST_NOTHING_DUE;
                else
                begin
                    s = order.pop_front();
                    busy = 1'b1;
                    busy_slot = s;
                    busy_period = slot_period[s];
                    busy_deadline = slot_deadline[s];
                    r.due_id = slot_id[s];
                    r.due_arg = slot_arg[s];
                end
            dotq_pkg::MODE_COMPLETE:
                if (!busy)
                    r.status = dotq_pkg::ST_SEQUENCE;
                else
                begin
                    if (busy_period != 0 && !done)
                    begin
                        slot_deadline[busy_slot] = busy_deadline + busy_period;
                        if (earlier(slot_deadline[busy_slot], now))
                            slot_deadline[busy_slot] = now + busy_period;
                        enqueue(busy_slot);
                    end
                    else
                        used[busy_slot] = 1'b0;
                    busy = 1'b0;
                end
            default:
                r.status = dotq_pkg::ST_PARAM;
        endcase
        r.tick = now;
        pending.push_back(r);
    endfunction

    function void check_response(logic [2:0] status, logic [7:0] due_id,
                                 logic [31:0] due_arg, logic [31:0] tick);
        response_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected response status=%0d", status);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (status !== e.status)
        begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
        end
        if (due_id !== e.due_id)
        begin
            $error("due_task_id: expected %0d, got %0d", e.due_id, due_id);
            errors++;
        end
        if (due_arg !== e.due_arg)
        begin
            $error("due_task_arg: expected %h, got %h", e.due_arg, due_arg);
            errors++;
        end
        if (tick !== e.tick)
        begin
            $error("current_tick: expected %h, got %h", e.tick, tick);
            errors++;
        end
    endfunction

    // Software view: is a task in flight right now.
    function bit has_task_in_flight();
        return busy;
    endfunction
endclass

module testbench;

    localparam int  CLK_HALF   = 4;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  RANDOM_REQ = 1750;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    logic [7:0]  task_id = '0;
    logic [31:0] task_arg = '0;
    logic [31:0] delay = '0;
    logic [31:0] period = '0;
    logic        run_result = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  due_task_id;
    logic [31:0] due_task_arg;
    logic [31:0] current_tick;

    // Idle percentages for each side; changed between phases.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    // Long receiver hold-off, counted down in the receiver process.
    int          recv_hold = 0;
    int          cycle_count = 0;

    timer_queue_scoreboard board;

    always #(CLK_HALF) clk = ~clk;

    deadline_ordered_task_timer_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .task_id      (task_id),
        .task_arg     (task_arg),
        .delay        (delay),
        .period       (period),
        .run_result   (run_result),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .due_task_id  (due_task_id),
        .due_task_arg (due_task_arg),
        .current_tick (current_tick)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Response side: sample at the rising edge, move out_ready at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_response(status, due_task_id, due_task_arg, current_tick);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one request and hold it until accepted; random idle first.
    // Valid stays up after acceptance until the next idle or drain.
    task automatic send_request(logic [2:0] m, logic [7:0] id, logic [31:0] arg,
                                logic [31:0] dly, logic [31:0] per, logic done);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        task_id    <= id;
        task_arg   <= arg;
        delay      <= dly;
        period     <= per;
        run_result <= done;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(m, id, arg, dly, per, done);
        @(negedge clk);
    endtask

    task automatic drain_responses();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // Small id pool keeps collisions and deletes of live tasks common.
    function automatic logic [7:0] pick_id();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'($urandom_range(255));
            2:       return 8'hFF;
            default: return 8'($urandom_range(12, 1));
        endcase
    endfunction

    // Short delays and periods mostly, so tasks come due; wide words too.
    function automatic logic [31:0] pick_span();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(3);
            2:       return 32'h8000_0000 - $urandom_range(1) ;
            3:       return 32'd0;
            default: return $urandom_range(12);
        endcase
    endfunction

    task automatic random_request();
        int  pick;
        bit  flight;
        pick = $urandom_range(99);
        flight = board.has_task_in_flight();
        if (pick < 3)
            send_request(3'($urandom_range(7, 5)), 8'($urandom()), $urandom(), $urandom(),
                         $urandom(), 1'($urandom_range(1)));
        else if (pick < 30)
            send_request(dotq_pkg::MODE_TICK, 8'($urandom()), $urandom(), $urandom(),
                         $urandom(), 1'($urandom_range(1)));
        else if (pick < 52)
            send_request(dotq_pkg::MODE_CREATE, pick_id(), $urandom(), pick_span(),
                         pick_span(), 1'($urandom_range(1)));
        else if (pick < 62)
            send_request(dotq_pkg::MODE_DELETE, pick_id(), $urandom(), $urandom(),
                         $urandom(), 1'($urandom_range(1)));
        else if (pick < 82 && !flight || pick < 70)
            send_request(dotq_pkg::MODE_POLL, 8'($urandom()), $urandom(), $urandom(),
                         $urandom(), 1'($urandom_range(1)));
        else
            send_request(dotq_pkg::MODE_COMPLETE, 8'($urandom()), $urandom(), $urandom(),
                         $urandom(), $urandom_range(3) == 0);
    endtask

    initial
    begin
        board = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: sequence errors, parameter errors, empty poll, not-found delete.
        send_request(dotq_pkg::MODE_POLL, 8'd0, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_COMPLETE, 8'd0, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_CREATE, 8'd0, '1, '1, '1, 1'b1);
        send_request(dotq_pkg::MODE_DELETE, 8'd0, '0, '0, '0, 1'b0);
        send_request(3'd7, 8'hFF, '1, '1, '1, 1'b1);
        send_request(dotq_pkg::MODE_DELETE, 8'd9, '0, '0, '0, 1'b0);
        // Equal deadlines keep creation order; a replaced id moves to the back.
        send_request(dotq_pkg::MODE_CREATE, 8'd1, 32'hAAAA_5555, 32'd0, 32'd3, 1'b0);
        send_request(dotq_pkg::MODE_CREATE, 8'd2, 32'h5555_AAAA, 32'd0, 32'd0, 1'b0);
        send_request(dotq_pkg::MODE_CREATE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1'b0);
        send_request(dotq_pkg::MODE_CREATE, 8'd1, 32'h1234_5678, 32'd0, 32'd2, 1'b0);
        send_request(dotq_pkg::MODE_POLL, 8'd0, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_POLL, 8'd0, '0, '0, '0, 1'b0);
        // Delete a queued id, then create that id again.
        send_request(dotq_pkg::MODE_DELETE, 8'd2, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_CREATE, 8'd2, 32'd7, 32'd1, 32'd0, 1'b0);
        send_request(dotq_pkg::MODE_COMPLETE, 8'd0, '0, '0, '0, 1'b1);
        send_request(dotq_pkg::MODE_POLL, 8'd0, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_COMPLETE, 8'd0, '0, '0, '0, 1'b0);
        // Tick ahead, then poll and complete a one-shot task.
        send_request(dotq_pkg::MODE_TICK, '1, '1, '1, '1, 1'b1);
        send_request(dotq_pkg::MODE_TICK, '0, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_TICK, '0, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_POLL, 8'd0, '0, '0, '0, 1'b0);
        send_request(dotq_pkg::MODE_COMPLETE, 8'd0, '0, '0, '0, 1'b0);
        // Fill the pool until it reports full.
        for (int i = 0; i < 17; i++)
            send_request(dotq_pkg::MODE_CREATE, 8'(20 + i), $urandom(), 32'd100, 32'd0,
                         1'b0);
        drain_responses();
        for (int i = 0; i < 17; i++)
            send_request(dotq_pkg::MODE_DELETE, 8'(20 + i), '0, '0, '0, 1'b0);

        // Random phases with the idle pattern swapped, then none.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 38 : 0;
            if (ph == 1)
            begin
                // Long receiver stall while requests keep coming.
                drain_responses();
                recv_hold = 300;
            end
            for (int n = 0; n < RANDOM_REQ / 3; n++)
            begin
                random_request();
                if (n == 200)
                    drain_responses();
            end
        end

        drain_responses();
        repeat (20) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
